// File: sv/ktsb_pkg.sv
// Package for the keyed timer slot bank: field widths, command and status codes,
// slot state codes, parameter defaults and the controller command struct.
// Used by the interfaces and all modules; depends on nothing.
package ktsb_pkg;

    localparam int MODE_W     = 3;
    localparam int KEY_W      = 16;
    localparam int DUR_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_ST_W  = 2;

    localparam int SLOTS_DEF    = 8;
    localparam int KEY_BITS_DEF = 16;

    // Command modes.
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CHECK = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_INACTIVE    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ACTIVE      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EXPIRED     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NAME_EXISTS = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_UNAVAILABLE = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_TICK_DONE   = 3'd5;

    // Per-slot states.
    localparam logic [SLOT_ST_W-1:0] SLOT_INACTIVE = 2'd0;
    localparam logic [SLOT_ST_W-1:0] SLOT_ACTIVE   = 2'd1;
    localparam logic [SLOT_ST_W-1:0] SLOT_EXPIRED  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted item and clear the scan results
        logic rd_en;   // read the slot memories at the scan address
        logic proc;    // read data of the previous scan address is valid
        logic commit;  // apply the command and load the result register
    } ctrl_cmd_t;

endpackage

// File: sv/ktsb_if.sv
// Handshake channel interfaces for the keyed timer slot bank.
// Depends on ktsb_pkg for the payload widths.
interface ktsb_req_if;
    logic                          valid;
    logic                          ready;
    logic [ktsb_pkg::MODE_W-1:0]   mode;
    logic [ktsb_pkg::KEY_W-1:0]    name_key;
    logic [ktsb_pkg::DUR_W-1:0]    duration;

    modport source (output valid, output mode, output name_key, output duration, input ready);
    modport sink   (input valid, input mode, input name_key, input duration, output ready);
endinterface

interface ktsb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ktsb_pkg::STATUS_W-1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

// File: sv/ktsb_ctrl.sv
// Controller of the keyed timer slot bank: sequences the slot scan for each item
// and owns the result valid flag. Depends on ktsb_pkg.
module ktsb_ctrl #(
    parameter int SLOTS = ktsb_pkg::SLOTS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ktsb_pkg::ctrl_cmd_t cmd,
    output logic [IW-1:0]       rd_addr,
    output logic [IW-1:0]       proc_addr
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          proc_reg;
    logic [IW-1:0] paddr_reg;
    logic          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold the finished item until the result register is free.
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.proc = proc_reg;
    end

    assign rd_addr   = idx_reg;
    assign proc_addr = paddr_reg;
    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            proc_reg      <= 1'b0;
            paddr_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            proc_reg      <= cmd.rd_en;
            paddr_reg     <= idx_reg;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp_valid)
        else $error("result not presented after commit");

    a_proc_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.proc |-> $past(cmd.rd_en))
        else $error("slot processed without a preceding read");

    a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (cmd.rd_en && rd_addr == '0))
        else $error("scan did not start at slot zero after load");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !cmd.commit)
        else $error("commit while a result is still waiting");
`endif

endmodule

// File: sv/ktsb_dp.sv
// Datapath of the keyed timer slot bank: item registers, slot state flops,
// key/count/limit memories, scan results and the result register.
// Depends on ktsb_pkg; driven by ktsb_ctrl.
module ktsb_dp #(
    parameter int SLOTS    = ktsb_pkg::SLOTS_DEF,
    parameter int KEY_BITS = ktsb_pkg::KEY_BITS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ktsb_pkg::ctrl_cmd_t             cmd,
    input  logic [IW-1:0]                   rd_addr,
    input  logic [IW-1:0]                   proc_addr,
    input  logic [ktsb_pkg::MODE_W-1:0]     mode,
    input  logic [ktsb_pkg::KEY_W-1:0]      name_key,
    input  logic [ktsb_pkg::DUR_W-1:0]      duration,
    output logic [ktsb_pkg::STATUS_W-1:0]   status
);

    // Only the low KEY_BITS bits of the key count, capped at the 16-bit width of the field.
    localparam int KW = (KEY_BITS < ktsb_pkg::KEY_W) ? KEY_BITS : ktsb_pkg::KEY_W;
    localparam int DW = ktsb_pkg::DUR_W;
    localparam int SW = ktsb_pkg::SLOT_ST_W;

    logic [ktsb_pkg::MODE_W-1:0]  mode_reg;
    logic [KW-1:0]                key_reg;
    logic [DW-1:0]                dur_reg;

    logic [SW-1:0]                slot_st_reg [SLOTS];
    logic [KW-1:0]                key_mem [SLOTS];
    logic [DW-1:0]                cnt_mem [SLOTS];
    logic [DW-1:0]                lim_mem [SLOTS];
    logic [KW-1:0]                key_q;
    logic [DW-1:0]                cnt_q;
    logic [DW-1:0]                lim_q;

    logic                         hit_reg;
    logic [IW-1:0]                hit_idx_reg;
    logic [SW-1:0]                hit_st_reg;
    logic                         free_reg;
    logic [IW-1:0]                free_idx_reg;
    logic [ktsb_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [SW-1:0]                cur_st;
    logic                         live;
    logic                         match;
    logic [DW-1:0]                cnt_inc;

    logic                         st_we;
    logic [IW-1:0]                st_waddr;
    logic [SW-1:0]                st_wdata;
    logic                         cnt_we;
    logic                         kl_we;
    logic [IW-1:0]                mem_waddr;
    logic [DW-1:0]                cnt_wdata;

    assign cur_st  = slot_st_reg[proc_addr];
    assign live    = (cur_st != ktsb_pkg::SLOT_INACTIVE);
    assign match   = live && (key_q == key_reg);
    assign cnt_inc = (cnt_q == {DW{1'b1}}) ? cnt_q : cnt_q + DW'(1);

    always_comb
    begin
        st_we       = 1'b0;
        st_waddr    = proc_addr;
        st_wdata    = ktsb_pkg::SLOT_INACTIVE;
        cnt_we      = 1'b0;
        kl_we       = 1'b0;
        mem_waddr   = proc_addr;
        cnt_wdata   = cnt_inc;
        status_next = status_reg;

        // A tick updates each active slot as the scan passes it.
        if (cmd.proc && mode_reg == ktsb_pkg::MODE_TICK
            && cur_st == ktsb_pkg::SLOT_ACTIVE)
        begin
            cnt_we = 1'b1;
            if (cnt_inc >= lim_q)
            begin
                st_we    = 1'b1;
                st_wdata = ktsb_pkg::SLOT_EXPIRED;
            end
        end

        if (cmd.commit)
        begin
            case (mode_reg)
                ktsb_pkg::MODE_TICK:
                begin
                    status_next = ktsb_pkg::STAT_TICK_DONE;
                end
                ktsb_pkg::MODE_START:
                begin
                    if (hit_reg)
                    begin
                        status_next = ktsb_pkg::STAT_NAME_EXISTS;
                    end
                    else if (!free_reg)
                    begin
                        status_next = ktsb_pkg::STAT_UNAVAILABLE;
                    end
                    else
                    begin
                        status_next = ktsb_pkg::STAT_ACTIVE;
                        st_we       = 1'b1;
                        st_waddr    = free_idx_reg;
                        st_wdata    = ktsb_pkg::SLOT_ACTIVE;
                        cnt_we      = 1'b1;
                        kl_we       = 1'b1;
                        mem_waddr   = free_idx_reg;
                        cnt_wdata   = '0;
                    end
                end
                ktsb_pkg::MODE_STOP:
                begin
                    if (hit_reg)
                    begin
                        // Count and limit are rewritten by the next start of this slot.
                        status_next = ktsb_pkg::STAT_INACTIVE;
                        st_we       = 1'b1;
                        st_waddr    = hit_idx_reg;
                        st_wdata    = ktsb_pkg::SLOT_INACTIVE;
                    end
                    else
                    begin
                        status_next = ktsb_pkg::STAT_UNAVAILABLE;
                    end
                end
                ktsb_pkg::MODE_RESET:
                begin
                    if (hit_reg)
                    begin
                        status_next = ktsb_pkg::STAT_ACTIVE;
                        st_we       = 1'b1;
                        st_waddr    = hit_idx_reg;
                        st_wdata    = ktsb_pkg::SLOT_ACTIVE;
                        cnt_we      = 1'b1;
                        mem_waddr   = hit_idx_reg;
                        cnt_wdata   = '0;
                    end
                    else
                    begin
                        status_next = ktsb_pkg::STAT_UNAVAILABLE;
                    end
                end
                ktsb_pkg::MODE_CHECK:
                begin
                    status_next = hit_reg ? ktsb_pkg::STATUS_W'(hit_st_reg)
                                          : ktsb_pkg::STAT_INACTIVE;
                end
                default:
                begin
                    status_next = ktsb_pkg::STAT_UNAVAILABLE;
                end
            endcase
        end
    end

    // Item capture and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            key_reg  <= name_key[KW-1:0];
            dur_reg  <= duration;
        end
        status_reg <= status_next;
    end

    // Slot memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[mem_waddr] <= cnt_wdata;
        end
        if (kl_we)
        begin
            key_mem[mem_waddr] <= key_reg;
            lim_mem[mem_waddr] <= dur_reg;
        end
        if (cmd.rd_en)
        begin
            key_q <= key_mem[rd_addr];
            cnt_q <= cnt_mem[rd_addr];
            lim_q <= lim_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_st_reg[i] <= ktsb_pkg::SLOT_INACTIVE;
            end
        end
        else if (st_we)
        begin
            slot_st_reg[st_waddr] <= st_wdata;
        end
    end

    // Scan results: first live slot holding the key and first free slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            hit_st_reg   <= ktsb_pkg::SLOT_INACTIVE;
            free_reg     <= 1'b0;
            free_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.proc)
        begin
            if (match && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= proc_addr;
                hit_st_reg  <= cur_st;
            end
            if (!live && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= proc_addr;
            end
        end
    end

    assign status = status_reg;

endmodule

// File: sv/keyed_timer_slot_bank.sv
// Keyed timer slot bank: a table of SLOTS tick-driven timers looked up by key.
// Usage:
//   req carries one command per item (mode, name_key, duration): tick, start,
//   stop, reset or check. rsp returns exactly one status per item.
//   Each item scans every slot once through the key/count/limit memories, one
//   slot per cycle. The result becomes valid in the same cycle that req is ready
//   again, so the block finishes each item before it takes the next one.
//   The scan length is set by the single read port of the slot memories.
//   req is ready while a previous result still waits on rsp; when rsp is
//   stalled the finished item holds in its last step until the result
//   register is free, and rsp.status stays stable until taken.
//   Reset marks every slot inactive at once; no clearing pass is needed,
//   since keys, counts and limits are only used for live slots.
// Depends on ktsb_pkg, ktsb_if, ktsb_ctrl and ktsb_dp.
module keyed_timer_slot_bank #(
    parameter int SLOTS    = ktsb_pkg::SLOTS_DEF,
    parameter int KEY_BITS = ktsb_pkg::KEY_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ktsb_req_if.sink   req,
    ktsb_rsp_if.source rsp
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    ktsb_pkg::ctrl_cmd_t cmd;
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       proc_addr;

    ktsb_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .proc_addr (proc_addr)
    );

    ktsb_dp #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .proc_addr (proc_addr),
        .mode      (req.mode),
        .name_key  (req.name_key),
        .duration  (req.duration),
        .status    (rsp.status)
    );

endmodule

// File: tb/tb_keyed_timer_slot_bank.sv
// Self-checking testbench for the keyed timer slot bank: a shadow timer table
// predicts every status, a driver and a monitor run the two handshake channels.
// Depends on ktsb_pkg, the ktsb_req_if/ktsb_rsp_if interfaces and the block itself.
module tb_keyed_timer_slot_bank;

    localparam int SLOTS      = ktsb_pkg::SLOTS_DEF;
    localparam int KEY_BITS   = ktsb_pkg::KEY_BITS_DEF;
    localparam int MODE_W     = ktsb_pkg::MODE_W;
    localparam int KEY_W      = ktsb_pkg::KEY_W;
    localparam int DUR_W      = ktsb_pkg::DUR_W;
    localparam int STATUS_W   = ktsb_pkg::STATUS_W;
    localparam int SLOT_ST_W  = ktsb_pkg::SLOT_ST_W;
    localparam int PERIOD     = 4;
    localparam int RESET_CYC  = 7;
    localparam int RAND_ITEMS = 830;
    localparam int IDLE_PCT   = 28;
    localparam int QUIET_FROM = 350;
    localparam int QUIET_TO   = 500;
    localparam int HOLD_AT    = 620;
    localparam int HOLD_LEN   = 250;
    localparam int DRAIN_CYC  = 40;
    localparam int POOL_SIZE  = 12;

    localparam logic [KEY_W-1:0]  KEY_MASK     = KEY_W'((1 << KEY_BITS) - 1);
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [DUR_W-1:0]  dur;
    } tmr_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    ktsb_req_if req_ch ();
    ktsb_rsp_if rsp_ch ();

    keyed_timer_slot_bank #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(PERIOD/2) clk = ~clk;

    // Shadow copy of the timer table.
    logic [SLOT_ST_W-1:0] shadow_state [SLOTS];
    logic [KEY_W-1:0]     shadow_key   [SLOTS];
    logic [DUR_W-1:0]     shadow_count [SLOTS];
    logic [DUR_W-1:0]     shadow_limit [SLOTS];

    tmr_cmd_t            cmd_queue  [$];
    logic [STATUS_W-1:0] status_exp [$];
    logic [KEY_W-1:0]    key_pool   [POOL_SIZE];

    int n_sent = 0;
    int n_rsp = 0;
    int n_errors = 0;
    int status_seen [8] = '{default: 0};

    function automatic logic [STATUS_W-1:0] predict_status(tmr_cmd_t c);
        logic [KEY_W-1:0]    k;
        logic [STATUS_W-1:0] st;
        int                  hit;
        int                  free_idx;
        k        = c.key & KEY_MASK;
        hit      = -1;
        free_idx = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_state[i] != ktsb_pkg::SLOT_INACTIVE && shadow_key[i] == k && hit < 0)
                hit = i;
            if (shadow_state[i] == ktsb_pkg::SLOT_INACTIVE && free_idx < 0)
                free_idx = i;
        end
        case (c.mode)
            ktsb_pkg::MODE_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (shadow_state[i] == ktsb_pkg::SLOT_ACTIVE)
                    begin
                        if (shadow_count[i] != '1)
                            shadow_count[i] = shadow_count[i] + 1;
                        if (shadow_count[i] >= shadow_limit[i])
                            shadow_state[i] = ktsb_pkg::SLOT_EXPIRED;
                    end
                end
                st = ktsb_pkg::STAT_TICK_DONE;
            end
            ktsb_pkg::MODE_START:
            begin
                if (hit >= 0)
                    st = ktsb_pkg::STAT_NAME_EXISTS;
                else if (free_idx < 0)
                    st = ktsb_pkg::STAT_UNAVAILABLE;
                else
                begin
                    shadow_state[free_idx] = ktsb_pkg::SLOT_ACTIVE;
                    shadow_key[free_idx]   = k;
                    shadow_count[free_idx] = '0;
                    shadow_limit[free_idx] = c.dur;
                    st = ktsb_pkg::STAT_ACTIVE;
                end
            end
            ktsb_pkg::MODE_STOP:
            begin
                if (hit < 0)
                    st = ktsb_pkg::STAT_UNAVAILABLE;
                else
                begin
                    shadow_state[hit] = ktsb_pkg::SLOT_INACTIVE;
                    shadow_count[hit] = '0;
                    shadow_limit[hit] = '0;
                    st = ktsb_pkg::STAT_INACTIVE;
                end
            end
            ktsb_pkg::MODE_RESET:
            begin
                if (hit < 0)
                    st = ktsb_pkg::STAT_UNAVAILABLE;
                else
                begin
                    shadow_count[hit] = '0;
                    shadow_state[hit] = ktsb_pkg::SLOT_ACTIVE;
                    st = ktsb_pkg::STAT_ACTIVE;
                end
            end
            ktsb_pkg::MODE_CHECK:
            begin
                if (hit < 0)
                    st = ktsb_pkg::STAT_INACTIVE;
                else
                    st = STATUS_W'(shadow_state[hit]);
            end
            default:
                st = ktsb_pkg::STAT_UNAVAILABLE;
        endcase
        return st;
    endfunction

    task automatic report_mismatch(string what, int exp_v, int got_v);
        $display("MISMATCH at result %0d: %s, expected %0d, got %0d",
                 n_rsp, what, exp_v, got_v);
        n_errors++;
    endtask

    task automatic push_cmd(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                            logic [DUR_W-1:0] d);
        tmr_cmd_t c;
        c.mode = m;
        c.key  = k;
        c.dur  = d;
        cmd_queue.push_back(c);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        if ($urandom_range(0, 99) < 90)
            k = key_pool[$urandom_range(0, POOL_SIZE-1)];
        else
            k = KEY_W'($urandom);
        return k;
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int               r;
        logic [DUR_W-1:0] d;
        r = $urandom_range(0, 99);
        if (r < 70)
            d = DUR_W'($urandom_range(0, 12));
        else if (r < 85)
            d = DUR_W'($urandom_range(0, 200));
        else
            d = DUR_W'($urandom);
        return d;
    endfunction

    // Driver: offers the next pending item and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        tmr_cmd_t cmd_now;
        tmr_cmd_t cmd_next;
        logic     gap;
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.mode     <= ktsb_pkg::MODE_TICK;
            req_ch.name_key <= '0;
            req_ch.duration <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                shadow_state[i] = ktsb_pkg::SLOT_INACTIVE;
                shadow_key[i]   = '0;
                shadow_count[i] = '0;
                shadow_limit[i] = '0;
            end
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                cmd_now.mode = req_ch.mode;
                cmd_now.key  = req_ch.name_key;
                cmd_now.dur  = req_ch.duration;
                status_exp.push_back(predict_status(cmd_now));
                n_sent++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                gap = (n_sent < QUIET_FROM || n_sent >= QUIET_TO) &&
                      ($urandom_range(0, 99) < IDLE_PCT);
                if (cmd_queue.size() != 0 && !gap)
                begin
                    cmd_next = cmd_queue.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.mode     <= cmd_next.mode;
                    req_ch.name_key <= cmd_next.key;
                    req_ch.duration <= cmd_next.dur;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result and throttles the result channel.
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        int                  hold_left;
        logic                hold_done;
        logic [STATUS_W-1:0] want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (status_exp.size() == 0)
                begin
                    report_mismatch("result with no item outstanding", -1,
                                    int'(rsp_ch.status));
                end
                else
                begin
                    want = status_exp.pop_front();
                    if (rsp_ch.status !== want)
                        report_mismatch("status", int'(want), int'(rsp_ch.status));
                end
                status_seen[rsp_ch.status]++;
                n_rsp++;
            end
            // One long hold-off lets the block fill up and stall its input.
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (n_rsp >= HOLD_AT && !hold_done)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
            end
            else if ((n_rsp < QUIET_FROM || n_rsp >= QUIET_TO) &&
                     ($urandom_range(0, 99) < IDLE_PCT))
            begin
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : limit_proc
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stim_proc
        int r;
        rst_n = 1'b0;

        // Directed part: lookups on an empty table, zero duration, expired
        // slots, a full table, unused modes and freeing a slot for reuse.
        push_cmd(ktsb_pkg::MODE_CHECK, 16'h0000, 32'h0);
        push_cmd(ktsb_pkg::MODE_STOP,  16'hFFFF, 32'h0);
        push_cmd(ktsb_pkg::MODE_RESET, 16'h1234, 32'h0);
        push_cmd(ktsb_pkg::MODE_TICK,  16'h0000, 32'h0);
        push_cmd(ktsb_pkg::MODE_START, 16'h0000, 32'h0);
        push_cmd(ktsb_pkg::MODE_START, 16'h0000, 32'h5);
        push_cmd(ktsb_pkg::MODE_TICK,  16'hFFFF, 32'hFFFF_FFFF);
        push_cmd(ktsb_pkg::MODE_CHECK, 16'h0000, 32'h0);
        push_cmd(ktsb_pkg::MODE_START, 16'h0000, 32'h7);
        push_cmd(ktsb_pkg::MODE_RESET, 16'h0000, 32'h0);
        push_cmd(ktsb_pkg::MODE_CHECK, 16'h0000, 32'h0);
        push_cmd(ktsb_pkg::MODE_START, 16'hFFFF, 32'hFFFF_FFFF);
        for (int i = 1; i <= 6; i++)
            push_cmd(ktsb_pkg::MODE_START, KEY_W'(i), 32'h2);
        push_cmd(ktsb_pkg::MODE_START, 16'h00A5, 32'h1);
        push_cmd(MODE_SPARE_A, 16'hFFFF, 32'hFFFF_FFFF);
        push_cmd(MODE_SPARE_B, 16'h0001, 32'h0);
        push_cmd(MODE_SPARE_C, 16'h0000, 32'h0);
        push_cmd(ktsb_pkg::MODE_TICK,  16'h0000, 32'h0);
        push_cmd(ktsb_pkg::MODE_TICK,  16'h0000, 32'h0);
        push_cmd(ktsb_pkg::MODE_STOP,  16'h0003, 32'h0);
        push_cmd(ktsb_pkg::MODE_START, 16'h5A5A, 32'h1);
        push_cmd(ktsb_pkg::MODE_CHECK, 16'hFFFF, 32'h0);

        // Random part: a small key pool keeps starts, stops and lookups
        // colliding, with a few stray keys and unused modes as noise.
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 34)
                push_cmd(ktsb_pkg::MODE_TICK, KEY_W'($urandom), DUR_W'($urandom));
            else if (r < 54)
                push_cmd(ktsb_pkg::MODE_START, pick_key(), pick_duration());
            else if (r < 66)
                push_cmd(ktsb_pkg::MODE_STOP, pick_key(), DUR_W'($urandom));
            else if (r < 76)
                push_cmd(ktsb_pkg::MODE_RESET, pick_key(), DUR_W'($urandom));
            else if (r < 95)
                push_cmd(ktsb_pkg::MODE_CHECK, pick_key(), DUR_W'($urandom));
            else
            begin
                case ($urandom_range(0, 2))
                    0:       push_cmd(MODE_SPARE_A, pick_key(), DUR_W'($urandom));
                    1:       push_cmd(MODE_SPARE_B, pick_key(), DUR_W'($urandom));
                    default: push_cmd(MODE_SPARE_C, pick_key(), DUR_W'($urandom));
                endcase
            end
        end

        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sampling on the falling edge sees the settled state of each cycle.
        while (cmd_queue.size() != 0 || req_ch.valid || status_exp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Ran %0d commands through %0d timer slots, %0d results checked.",
                 n_sent, SLOTS, n_rsp);
        $display("Statuses: inactive %0d active %0d expired %0d exists %0d %s %0d tick %0d",
                 status_seen[ktsb_pkg::STAT_INACTIVE], status_seen[ktsb_pkg::STAT_ACTIVE],
                 status_seen[ktsb_pkg::STAT_EXPIRED], status_seen[ktsb_pkg::STAT_NAME_EXISTS],
                 "unavailable", status_seen[ktsb_pkg::STAT_UNAVAILABLE],
                 status_seen[ktsb_pkg::STAT_TICK_DONE]);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
